### sv/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
  localparam int AngleBits  = 16;
  localparam int QuatFrac   = 14;
  localparam int CordicIters = 28;
  localparam int CordicFrac = 30;
  localparam int CW         = 33;
  localparam int ZW         = 35;
  localparam int OutW       = 16;
  localparam int DataInW    = 48;
  localparam int DataOutW   = 64;
  localparam int IdxW       = 5;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  typedef struct packed {
    logic valid;
    cval_t [2:0] x;
    cval_t [2:0] y;
    zval_t [2:0] z;
  } cord_t;

  function automatic zval_t atan_step(input logic [IdxW-1:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
        5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
        5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
        5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
        5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
        5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
        5'd20: v = 32'd652;       5'd21: v = 32'd326;
        5'd22: v = 32'd163;       5'd23: v = 32'd81;
        5'd24: v = 32'd41;        5'd25: v = 32'd20;
        5'd26: v = 32'd10;        5'd27: v = 32'd5;
        default: v = 32'd0;
      endcase
      atan_step = zval_t'({v, 1'b0});
    end
  endfunction
endpackage
`default_nettype wire

### sv/euler_to_quaternion_unit.sv
// The path from the accepting edge to the result on the output runs through the
// entry stage, 28 CORDIC cells and 3 product and rounding stages.
// Throughput: one request per cycle; the whole chain advances while the
// output is free or taken, so a stall holds every stage.
// Reset clears the valid bits of every stage; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle
  input  wire logic [e2q_pkg::DataInW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [e2q_pkg::DataOutW-1:0]        m_axis_tdata
);
  import e2q_pkg::*;
  logic en;
  logic in_valid_q;
  zval_t [2:0] in_z_q;
  cord_t chain [CordicIters+1];
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        in_z_q[k] <= ZW'($signed(s_axis_tdata[16*k +: 16])) <<< (32 - AngleBits);
      end
    end
  end
  assign chain[0] = '{valid: in_valid_q, x: {3{CW'(652032874)}}, y: '0, z: in_z_q};
  for (genvar g = 0; g < CordicIters; g++) begin : g_cell
    e2q_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .idx_i(IdxW'(g)),
      .prev_i(chain[g]), .next_o(chain[g+1])
    );
  end
  e2q_combine u_comb (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .cs_i(chain[CordicIters]),
    .valid_o(m_axis_tvalid), .quat_o(m_axis_tdata)
  );
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(chain[CordicIters].valid))
    else $error("chain advanced under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
endmodule
`default_nettype wire

### sv/e2q_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic [4:0]           idx_i,
  input  wire e2q_pkg::cord_t       prev_i,
  output e2q_pkg::cord_t            next_o
);
  import e2q_pkg::*;
  cord_t d;
  zval_t da;
  cval_t dx, dy;
  logic valid_q;
  cval_t [2:0] x_q, y_q;
  zval_t [2:0] z_q;
  always_comb begin
    da = atan_step(idx_i);
    d.valid = prev_i.valid;
    for (int k = 0; k < 3; k++) begin
      dx = $signed(prev_i.y[k]) >>> idx_i;
      dy = $signed(prev_i.x[k]) >>> idx_i;
      if (!prev_i.z[k][ZW-1]) begin
        d.x[k] = prev_i.x[k] - dx;
        d.y[k] = prev_i.y[k] + dy;
        d.z[k] = prev_i.z[k] - da;
      end else begin
        d.x[k] = prev_i.x[k] + dx;
        d.y[k] = prev_i.y[k] - dy;
        d.z[k] = prev_i.z[k] + da;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= d.x;
      y_q <= d.y;
      z_q <= d.z;
    end
  end
  assign next_o = '{valid: valid_q, x: x_q, y: y_q, z: z_q};
endmodule
`default_nettype wire

### sv/e2q_combine.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire e2q_pkg::cord_t cs_i,
  output logic                valid_o,
  output logic [63:0]         quat_o
);
  import e2q_pkg::*;
  // stage 1: pair products rounded to Q30; stage 2: Q60 terms; stage 3: sum, round and saturate
  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;
  logic signed [CW-1:0] cpcy_q, spsy_q, spcy_q, cpsy_q, sr_q, cr_q;
  logic signed [65:0] pcpcy, pspsy, pspcy, pcpsy;
  logic signed [65:0] t_q [8];
  logic signed [66:0] s_d [4];
  logic signed [66:0] r;
  logic signed [OutW-1:0] o_d [4];
  logic [2:0] v_q;
  assign cr = cs_i.x[0]; assign sr = cs_i.y[0];
  assign cp = cs_i.x[1]; assign sp = cs_i.y[1];
  assign cy = cs_i.x[2]; assign sy = cs_i.y[2];
  assign pcpcy = 66'(cp) * 66'(cy) + (66'sd1 <<< (CordicFrac - 1));
  assign pspsy = 66'(sp) * 66'(sy) + (66'sd1 <<< (CordicFrac - 1));
  assign pspcy = 66'(sp) * 66'(cy) + (66'sd1 <<< (CordicFrac - 1));
  assign pcpsy = 66'(cp) * 66'(sy) + (66'sd1 <<< (CordicFrac - 1));
  always_comb begin
    s_d[0] = {t_q[0][65], t_q[0]} - {t_q[1][65], t_q[1]};
    s_d[1] = {t_q[2][65], t_q[2]} + {t_q[3][65], t_q[3]};
    s_d[2] = {t_q[4][65], t_q[4]} - {t_q[5][65], t_q[5]};
    s_d[3] = {t_q[6][65], t_q[6]} + {t_q[7][65], t_q[7]};
    for (int k = 0; k < 4; k++) begin
      r = (s_d[k] + (67'sd1 <<< (2 * CordicFrac - QuatFrac - 1)))
          >>> (2 * CordicFrac - QuatFrac);
      if (r > 67'sd16384) o_d[k] = 16'sd16384;
      else if (r < -67'sd16384) o_d[k] = -16'sd16384;
      else o_d[k] = r[OutW-1:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], cs_i.valid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cpcy_q <= CW'(pcpcy >>> CordicFrac); spsy_q <= CW'(pspsy >>> CordicFrac);
      spcy_q <= CW'(pspcy >>> CordicFrac); cpsy_q <= CW'(pcpsy >>> CordicFrac);
      sr_q <= sr; cr_q <= cr;
      t_q[0] <= 66'(sr_q) * 66'(cpcy_q); t_q[1] <= 66'(cr_q) * 66'(spsy_q);
      t_q[2] <= 66'(cr_q) * 66'(spcy_q); t_q[3] <= 66'(sr_q) * 66'(cpsy_q);
      t_q[4] <= 66'(cr_q) * 66'(cpsy_q); t_q[5] <= 66'(sr_q) * 66'(spcy_q);
      t_q[6] <= 66'(cr_q) * 66'(cpcy_q); t_q[7] <= 66'(sr_q) * 66'(spsy_q);
      quat_o <= {o_d[3], o_d[2], o_d[1], o_d[0]};
    end
  end
  assign valid_o = v_q[2];
endmodule
`default_nettype wire
